// File: rtl/core/ple_pkg.sv
// ----------------------------------------------------------------------------
// ple_pkg
// Shared types for the positional list engine: operation and status codes,
// controller states, and the command and status groups between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package ple_pkg;

  typedef enum logic [2:0] {
    K_INS_FRONT = 3'd0,
    K_INS_BACK  = 3'd1,
    K_INS_AT    = 3'd2,
    K_DEL_FRONT = 3'd3,
    K_DEL_BACK  = 3'd4,
    K_DEL_AT    = 3'd5,
    K_DUMP      = 3'd6,
    K_NOP       = 3'd7
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_BADPOS = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_FULL   = 2'd3
  } status_e;

  typedef enum logic [4:0] {
    S_IDLE,
    S_DECIDE,
    S_WALK_RD,
    S_WALK_WT,
    S_ALLOC,
    S_ALLOC_WT,
    S_INS_PRD,
    S_INS_PWT,
    S_INS_W1,
    S_INS_W2,
    S_DEL_RD,
    S_DEL_WT,
    S_DEL_W1,
    S_DEL_W2,
    S_DUMP_RD,
    S_DUMP_WT,
    S_RESP
  } state_e;

  typedef enum logic [2:0] {
    CUR_HOLD,
    CUR_HEAD,
    CUR_TAIL,
    CUR_NULL,
    CUR_FWD
  } cur_sel_e;

  typedef struct packed {
    logic     ld_item;
    logic     st_we;
    status_e  st;
    cur_sel_e cur_sel;
    logic     fwd_rd_cur;
    logic     val_rd;
    logic     bwd_rd;
    logic     alloc_fresh;
    logic     alloc_rd;
    logic     alloc_rec;
    logic     p_from_tail;
    logic     p_from_ram;
    logic     ins_w1;
    logic     ins_w2;
    logic     del_latch;
    logic     del_w1;
    logic     del_w2;
    logic     dump_emit;
    logic     resp_emit;
  } cmd_t;

  typedef struct packed {
    kind_e kind;
    logic  full;
    logic  empty;
    logic  ins_pos_bad;
    logic  ins_at_end;
    logic  del_pos_bad;
    logic  rem_zero;
    logic  rec_null;
    logic  cur_null;
    logic  fwd_null;
    logic  out_free;
  } sts_t;

endpackage

// File: rtl/core/ple_ram.sv
// ----------------------------------------------------------------------------
// ple_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module ple_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/core/ple_datapath.sv
// ----------------------------------------------------------------------------
// ple_datapath
// Link, value and pointer storage, the walk cursor and the output register
// of the positional list engine.
// ----------------------------------------------------------------------------
module ple_datapath #(
  parameter int CAPACITY   = 32,
  parameter int DATA_WIDTH = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ple_pkg::cmd_t      cmd_i,
  output ple_pkg::sts_t      sts_o,
  input  logic [2:0]         kind_i,
  input  logic signed [31:0] value_in_i,
  input  logic [7:0]         position_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [1:0]         status_o,
  output logic [5:0]         count_o,
  output logic signed [31:0] value_out_o,
  output logic               last_o
);

  localparam int IW = $clog2(CAPACITY + 1);
  localparam int AW = $clog2(CAPACITY);
  localparam int PW = (IW + 1 > 9) ? IW + 1 : 9;
  localparam logic [IW-1:0] NULL_IDX = IW'(CAPACITY);

  ple_pkg::kind_e   kind_q;
  logic [7:0]       pos_q;
  logic [DATA_WIDTH-1:0] val_q;
  logic [IW-1:0]    head_q, head_d, tail_q, tail_d, rec_q, rec_d, fresh_q, fresh_d;
  logic [IW-1:0]    cnt_q, cnt_d;
  logic [IW-1:0]    cur_q, cur_d, n_q, n_d, p_q, p_d, nx_q, nx_d;
  logic [7:0]       rem_q, rem_d;
  ple_pkg::status_e st_q;

  logic               out_valid_q;
  logic [1:0]         ostatus_q;
  logic [5:0]         ocount_q;
  logic signed [31:0] ovalue_q;
  logic               olast_q;

  logic                  fwd_we, bwd_we, fwd_re;
  logic [IW-1:0]         fwd_wa, fwd_wd, bwd_wa, bwd_wd, fwd_ra;
  logic [IW-1:0]         fwd_rdata, bwd_rdata;
  logic [DATA_WIDTH-1:0] val_rdata;
  logic signed [DATA_WIDTH-1:0] val_s;
  logic [PW-1:0]         pos_ext, cnt_ext;
  logic                  p_null, nx_null, cur_null, out_free;

  assign p_null   = (p_q == NULL_IDX);
  assign nx_null  = (nx_q == NULL_IDX);
  assign cur_null = (cur_q == NULL_IDX);
  assign out_free = !out_valid_q || !out_stall_i;
  assign pos_ext  = PW'(pos_q);
  assign cnt_ext  = PW'(cnt_q);
  assign val_s    = val_rdata;

  // link memory ports
  always_comb begin
    fwd_we = 1'b0;
    fwd_wa = n_q;
    fwd_wd = cur_q;
    bwd_we = 1'b0;
    bwd_wa = n_q;
    bwd_wd = p_q;
    if (cmd_i.ins_w1) begin
      fwd_we = 1'b1;
      bwd_we = 1'b1;
    end else if (cmd_i.ins_w2) begin
      fwd_we = !p_null;
      fwd_wa = p_q;
      fwd_wd = n_q;
      bwd_we = !cur_null;
      bwd_wa = cur_q;
      bwd_wd = n_q;
    end else if (cmd_i.del_w1) begin
      fwd_we = !p_null;
      fwd_wa = p_q;
      fwd_wd = nx_q;
      bwd_we = !nx_null;
      bwd_wa = nx_q;
      bwd_wd = p_q;
    end else if (cmd_i.del_w2) begin
      fwd_we = 1'b1;
      fwd_wa = cur_q;
      fwd_wd = rec_q;
    end
  end

  assign fwd_re = cmd_i.alloc_rd || cmd_i.fwd_rd_cur;
  assign fwd_ra = cmd_i.alloc_rd ? rec_q : cur_q;

  ple_ram #(.WIDTH(IW), .DEPTH(CAPACITY)) u_fwd (
    .clk_i   (clk_i),
    .we_i    (fwd_we),
    .waddr_i (fwd_wa[AW-1:0]),
    .wdata_i (fwd_wd),
    .re_i    (fwd_re),
    .raddr_i (fwd_ra[AW-1:0]),
    .rdata_o (fwd_rdata)
  );

  ple_ram #(.WIDTH(IW), .DEPTH(CAPACITY)) u_bwd (
    .clk_i   (clk_i),
    .we_i    (bwd_we),
    .waddr_i (bwd_wa[AW-1:0]),
    .wdata_i (bwd_wd),
    .re_i    (cmd_i.bwd_rd),
    .raddr_i (cur_q[AW-1:0]),
    .rdata_o (bwd_rdata)
  );

  ple_ram #(.WIDTH(DATA_WIDTH), .DEPTH(CAPACITY)) u_val (
    .clk_i   (clk_i),
    .we_i    (cmd_i.ins_w1),
    .waddr_i (n_q[AW-1:0]),
    .wdata_i (val_q),
    .re_i    (cmd_i.val_rd),
    .raddr_i (cur_q[AW-1:0]),
    .rdata_o (val_rdata)
  );

  // pointer and cursor update
  always_comb begin
    head_d  = head_q;
    tail_d  = tail_q;
    rec_d   = rec_q;
    fresh_d = fresh_q;
    cnt_d   = cnt_q;
    n_d     = n_q;
    p_d     = p_q;
    nx_d    = nx_q;
    cur_d   = cur_q;
    rem_d   = rem_q;
    unique case (cmd_i.cur_sel)
      ple_pkg::CUR_HOLD: cur_d = cur_q;
      ple_pkg::CUR_HEAD: begin
        cur_d = head_q;
        rem_d = pos_q - 8'd1;
      end
      ple_pkg::CUR_TAIL: cur_d = tail_q;
      ple_pkg::CUR_NULL: cur_d = NULL_IDX;
      ple_pkg::CUR_FWD: begin
        cur_d = fwd_rdata;
        rem_d = rem_q - 8'd1;
      end
      default: cur_d = cur_q;
    endcase
    if (cmd_i.alloc_fresh) begin
      n_d     = fresh_q;
      fresh_d = fresh_q + IW'(1);
    end
    if (cmd_i.alloc_rec) begin
      n_d   = rec_q;
      rec_d = fwd_rdata;
    end
    if (cmd_i.p_from_tail) begin
      p_d = tail_q;
    end
    if (cmd_i.p_from_ram || cmd_i.del_latch) begin
      p_d = bwd_rdata;
    end
    if (cmd_i.del_latch) begin
      nx_d = fwd_rdata;
    end
    if (cmd_i.ins_w2) begin
      if (p_null) begin
        head_d = n_q;
      end
      if (cur_null) begin
        tail_d = n_q;
      end
      cnt_d = cnt_q + IW'(1);
    end
    if (cmd_i.del_w1) begin
      if (p_null) begin
        head_d = nx_q;
      end
      if (nx_null) begin
        tail_d = p_q;
      end
    end
    if (cmd_i.del_w2) begin
      rec_d = cur_q;
      cnt_d = cnt_q - IW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= NULL_IDX;
      tail_q      <= NULL_IDX;
      rec_q       <= NULL_IDX;
      fresh_q     <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      head_q      <= head_d;
      tail_q      <= tail_d;
      rec_q       <= rec_d;
      fresh_q     <= fresh_d;
      cnt_q       <= cnt_d;
      out_valid_q <= (cmd_i.dump_emit || cmd_i.resp_emit) ? 1'b1 :
                     (out_stall_i ? out_valid_q : 1'b0);
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    rem_q <= rem_d;
    n_q   <= n_d;
    p_q   <= p_d;
    nx_q  <= nx_d;
    if (cmd_i.ld_item) begin
      kind_q <= ple_pkg::kind_e'(kind_i);
      pos_q  <= position_i;
      val_q  <= DATA_WIDTH'(value_in_i);
    end
    if (cmd_i.st_we) begin
      st_q <= cmd_i.st;
    end
    if (cmd_i.dump_emit) begin
      ostatus_q <= ple_pkg::ST_OK;
      ocount_q  <= 6'(cnt_q);
      ovalue_q  <= 32'(val_s);
      olast_q   <= (fwd_rdata == NULL_IDX);
    end else if (cmd_i.resp_emit) begin
      ostatus_q <= st_q;
      ocount_q  <= 6'(cnt_q);
      ovalue_q  <= '0;
      olast_q   <= 1'b1;
    end
  end

  always_comb begin
    sts_o.kind        = kind_q;
    sts_o.full        = (cnt_q == IW'(CAPACITY));
    sts_o.empty       = (cnt_q == '0);
    sts_o.ins_pos_bad = (pos_q == 8'd0) || (pos_ext > cnt_ext + PW'(1));
    sts_o.ins_at_end  = (pos_ext == cnt_ext + PW'(1));
    sts_o.del_pos_bad = (pos_q == 8'd0) || (pos_ext > cnt_ext);
    sts_o.rem_zero    = (rem_q == 8'd0);
    sts_o.rec_null    = (rec_q == NULL_IDX);
    sts_o.cur_null    = cur_null;
    sts_o.fwd_null    = (fwd_rdata == NULL_IDX);
    sts_o.out_free    = out_free;
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = ostatus_q;
  assign count_o     = ocount_q;
  assign value_out_o = ovalue_q;
  assign last_o      = olast_q;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= IW'(CAPACITY)) else $error("count above capacity");
  a_ends_agree: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (head_q == NULL_IDX) == (tail_q == NULL_IDX)) else $error("head and tail disagree");
  a_fresh_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fresh_q <= IW'(CAPACITY)) else $error("fresh slot count overrun");
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.dump_emit || cmd_i.resp_emit) |-> out_free) else $error("output overwritten");

endmodule

// File: rtl/core/ple_ctrl.sv
// ----------------------------------------------------------------------------
// ple_ctrl
// Operation sequencer of the positional list engine: decodes an item, walks
// the links and orders the link updates and result emission.
// ----------------------------------------------------------------------------
module ple_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  ple_pkg::sts_t sts_i,
  output ple_pkg::cmd_t cmd_o
);

  ple_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ple_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ple_pkg::S_IDLE: if (in_valid_i) state_d = ple_pkg::S_DECIDE;
      ple_pkg::S_DECIDE: begin
        unique case (sts_i.kind)
          ple_pkg::K_INS_FRONT, ple_pkg::K_INS_BACK:
            state_d = sts_i.full ? ple_pkg::S_RESP : ple_pkg::S_ALLOC;
          ple_pkg::K_INS_AT: begin
            if (sts_i.full || sts_i.ins_pos_bad) state_d = ple_pkg::S_RESP;
            else if (sts_i.ins_at_end)           state_d = ple_pkg::S_ALLOC;
            else                                 state_d = ple_pkg::S_WALK_RD;
          end
          ple_pkg::K_DEL_FRONT, ple_pkg::K_DEL_BACK:
            state_d = sts_i.empty ? ple_pkg::S_RESP : ple_pkg::S_DEL_RD;
          ple_pkg::K_DEL_AT:
            state_d = (sts_i.empty || sts_i.del_pos_bad) ? ple_pkg::S_RESP
                                                         : ple_pkg::S_WALK_RD;
          ple_pkg::K_DUMP:
            state_d = sts_i.empty ? ple_pkg::S_RESP : ple_pkg::S_DUMP_RD;
          default: state_d = ple_pkg::S_RESP;
        endcase
      end
      ple_pkg::S_WALK_RD: begin
        if (!sts_i.rem_zero) begin
          state_d = ple_pkg::S_WALK_WT;
        end else if (sts_i.kind == ple_pkg::K_INS_AT) begin
          state_d = ple_pkg::S_ALLOC;
        end else begin
          state_d = ple_pkg::S_DEL_RD;
        end
      end
      ple_pkg::S_WALK_WT:  state_d = ple_pkg::S_WALK_RD;
      ple_pkg::S_ALLOC:
        state_d = sts_i.rec_null ? ple_pkg::S_INS_PRD : ple_pkg::S_ALLOC_WT;
      ple_pkg::S_ALLOC_WT: state_d = ple_pkg::S_INS_PRD;
      ple_pkg::S_INS_PRD:
        state_d = sts_i.cur_null ? ple_pkg::S_INS_W1 : ple_pkg::S_INS_PWT;
      ple_pkg::S_INS_PWT:  state_d = ple_pkg::S_INS_W1;
      ple_pkg::S_INS_W1:   state_d = ple_pkg::S_INS_W2;
      ple_pkg::S_INS_W2:   state_d = ple_pkg::S_RESP;
      ple_pkg::S_DEL_RD:   state_d = ple_pkg::S_DEL_WT;
      ple_pkg::S_DEL_WT:   state_d = ple_pkg::S_DEL_W1;
      ple_pkg::S_DEL_W1:   state_d = ple_pkg::S_DEL_W2;
      ple_pkg::S_DEL_W2:   state_d = ple_pkg::S_RESP;
      ple_pkg::S_DUMP_RD:  state_d = ple_pkg::S_DUMP_WT;
      ple_pkg::S_DUMP_WT: begin
        if (sts_i.out_free) begin
          state_d = sts_i.fwd_null ? ple_pkg::S_IDLE : ple_pkg::S_DUMP_RD;
        end
      end
      ple_pkg::S_RESP: if (sts_i.out_free) state_d = ple_pkg::S_IDLE;
      default: state_d = ple_pkg::S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o      = '0;
    cmd_o.st   = ple_pkg::ST_OK;
    in_stall_o = (state_q != ple_pkg::S_IDLE);
    unique case (state_q)
      ple_pkg::S_IDLE: cmd_o.ld_item = in_valid_i;
      ple_pkg::S_DECIDE: begin
        cmd_o.st_we   = 1'b1;
        cmd_o.cur_sel = ple_pkg::CUR_HEAD;
        unique case (sts_i.kind)
          ple_pkg::K_INS_FRONT: if (sts_i.full) cmd_o.st = ple_pkg::ST_FULL;
          ple_pkg::K_INS_BACK: begin
            cmd_o.cur_sel = ple_pkg::CUR_NULL;
            if (sts_i.full) cmd_o.st = ple_pkg::ST_FULL;
          end
          ple_pkg::K_INS_AT: begin
            if (sts_i.ins_at_end) cmd_o.cur_sel = ple_pkg::CUR_NULL;
            if (sts_i.full)             cmd_o.st = ple_pkg::ST_FULL;
            else if (sts_i.ins_pos_bad) cmd_o.st = ple_pkg::ST_BADPOS;
          end
          ple_pkg::K_DEL_FRONT: if (sts_i.empty) cmd_o.st = ple_pkg::ST_EMPTY;
          ple_pkg::K_DEL_BACK: begin
            cmd_o.cur_sel = ple_pkg::CUR_TAIL;
            if (sts_i.empty) cmd_o.st = ple_pkg::ST_EMPTY;
          end
          ple_pkg::K_DEL_AT: begin
            if (sts_i.empty)            cmd_o.st = ple_pkg::ST_EMPTY;
            else if (sts_i.del_pos_bad) cmd_o.st = ple_pkg::ST_BADPOS;
          end
          ple_pkg::K_DUMP: if (sts_i.empty) cmd_o.st = ple_pkg::ST_EMPTY;
          default: cmd_o.st = ple_pkg::ST_OK;
        endcase
      end
      ple_pkg::S_WALK_RD:  cmd_o.fwd_rd_cur = !sts_i.rem_zero;
      ple_pkg::S_WALK_WT:  cmd_o.cur_sel = ple_pkg::CUR_FWD;
      ple_pkg::S_ALLOC: begin
        cmd_o.alloc_fresh = sts_i.rec_null;
        cmd_o.alloc_rd    = !sts_i.rec_null;
      end
      ple_pkg::S_ALLOC_WT: cmd_o.alloc_rec = 1'b1;
      ple_pkg::S_INS_PRD: begin
        cmd_o.p_from_tail = sts_i.cur_null;
        cmd_o.bwd_rd      = !sts_i.cur_null;
      end
      ple_pkg::S_INS_PWT:  cmd_o.p_from_ram = 1'b1;
      ple_pkg::S_INS_W1:   cmd_o.ins_w1 = 1'b1;
      ple_pkg::S_INS_W2:   cmd_o.ins_w2 = 1'b1;
      ple_pkg::S_DEL_RD: begin
        cmd_o.bwd_rd     = 1'b1;
        cmd_o.fwd_rd_cur = 1'b1;
      end
      ple_pkg::S_DEL_WT:   cmd_o.del_latch = 1'b1;
      ple_pkg::S_DEL_W1:   cmd_o.del_w1 = 1'b1;
      ple_pkg::S_DEL_W2:   cmd_o.del_w2 = 1'b1;
      ple_pkg::S_DUMP_RD: begin
        cmd_o.fwd_rd_cur = 1'b1;
        cmd_o.val_rd     = 1'b1;
      end
      ple_pkg::S_DUMP_WT: begin
        if (sts_i.out_free) begin
          cmd_o.dump_emit = 1'b1;
          cmd_o.cur_sel   = ple_pkg::CUR_FWD;
        end
      end
      ple_pkg::S_RESP:     cmd_o.resp_emit = sts_i.out_free;
      default:             cmd_o.ld_item = 1'b0;
    endcase
  end

  a_accept_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.ld_item |=> state_q == ple_pkg::S_DECIDE) else $error("item not decoded");
  a_one_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.ins_w1, cmd_o.ins_w2, cmd_o.del_w1, cmd_o.del_w2}))
    else $error("overlapping link writes");
  a_one_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_o.dump_emit && cmd_o.resp_emit)) else $error("double emit");

endmodule

// File: rtl/core/positional_list_engine_top.sv
// ----------------------------------------------------------------------------
// positional_list_engine_top
// Bounded doubly linked list of signed values with positional insert,
// delete and in-order dump.
// ----------------------------------------------------------------------------
// One item is worked at a time. Insert or delete at the front or back needs
// no walk; insert or delete at position p walks p-1 steps from the head, and
// each step of the walk is one read of the forward link RAM with registered
// read data. A dump reads the elements in order and waits on any output
// stall. The output register lets the next item be taken while a result
// waits. Reset needs no clearing pass: never used slots are handed out from
// a fill count, freed slots are chained for reuse.
module positional_list_engine_top #(
  parameter int CAPACITY   = 32,
  parameter int DATA_WIDTH = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [2:0]         kind_i,
  input  logic signed [31:0] value_in_i,
  input  logic [7:0]         position_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [1:0]         status_o,
  output logic [5:0]         count_o,
  output logic signed [31:0] value_out_o,
  output logic               last_o
);

  ple_pkg::cmd_t cmd;
  ple_pkg::sts_t sts;

  ple_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ple_datapath #(.CAPACITY(CAPACITY), .DATA_WIDTH(DATA_WIDTH)) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .kind_i      (kind_i),
    .value_in_i  (value_in_i),
    .position_i  (position_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_o    (status_o),
    .count_o     (count_o),
    .value_out_o (value_out_o),
    .last_o      (last_o)
  );

endmodule

// File: verif/positional_list_engine_top_test.sv
// ----------------------------------------------------------------------------
// positional_list_engine_top_test
// Self-checking bench for the positional list engine. A behavioral list model
// predicts status, count and dump contents for every item; results are
// compared in order under several idle and stall mixes.
// ----------------------------------------------------------------------------
module positional_list_engine_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CAP = 32;
  localparam int IDLE_LIMIT = 20000;

  typedef struct packed {
    ple_pkg::status_e status;
    logic [5:0]       count;
    logic [31:0]      value;
    logic             last;
  } list_result_t;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  logic [2:0]         kind_i;
  logic signed [31:0] value_in_i;
  logic [7:0]         position_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic [1:0]         status_o;
  logic [5:0]         count_o;
  logic signed [31:0] value_out_o;
  logic               last_o;

  positional_list_engine_top u_dut (.*);

  logic [31:0]  list_q[$];
  list_result_t pending_q[$];
  int           error_count;
  int           item_count;
  int           result_count;
  int           dump_count;
  int           idle_cycles;
  int           send_idle_pct;
  int           recv_stall_pct;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic list_result_t make_result(ple_pkg::status_e st, logic [31:0] v,
                                               logic l);
    list_result_t r;
    r.status = st;
    r.count  = 6'(list_q.size());
    r.value  = v;
    r.last   = l;
    return r;
  endfunction

  task automatic predict_list_op(ple_pkg::kind_e k, logic [31:0] v, int pos);
    ple_pkg::status_e st;
    st = ple_pkg::ST_OK;
    case (k)
      ple_pkg::K_INS_FRONT, ple_pkg::K_INS_BACK, ple_pkg::K_INS_AT: begin
        if (list_q.size() >= CAP) st = ple_pkg::ST_FULL;
        else if (k == ple_pkg::K_INS_FRONT) list_q.push_front(v);
        else if (k == ple_pkg::K_INS_BACK) list_q.push_back(v);
        else if (pos < 1 || pos > list_q.size() + 1) st = ple_pkg::ST_BADPOS;
        else list_q.insert(pos - 1, v);
      end
      ple_pkg::K_DEL_FRONT, ple_pkg::K_DEL_BACK, ple_pkg::K_DEL_AT: begin
        if (list_q.size() == 0) st = ple_pkg::ST_EMPTY;
        else if (k == ple_pkg::K_DEL_FRONT) void'(list_q.pop_front());
        else if (k == ple_pkg::K_DEL_BACK) void'(list_q.pop_back());
        else if (pos < 1 || pos > list_q.size()) st = ple_pkg::ST_BADPOS;
        else list_q.delete(pos - 1);
      end
      ple_pkg::K_DUMP: begin
        if (list_q.size() == 0) st = ple_pkg::ST_EMPTY;
        else begin
          foreach (list_q[i]) pending_q.push_back(make_result(ple_pkg::ST_OK, list_q[i],
                                                              i == list_q.size() - 1));
          return;
        end
      end
      default: ;
    endcase
    pending_q.push_back(make_result(st, '0, 1'b1));
  endtask

  task automatic report_mismatch(string what, int got, int exp);
    error_count++;
    $display("mismatch %s: got %0h expected %0h (result %0d)", what, got, exp,
             result_count);
  endtask

  task automatic send_item(ple_pkg::kind_e k, logic [31:0] v, int pos);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    kind_i     <= k;
    value_in_i <= v;
    position_i <= 8'(pos);
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_list_op(k, v, pos);
    item_count++;
    if (k == ple_pkg::K_DUMP) dump_count++;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (pending_q.size() == 0) begin
          report_mismatch("unexpected result", status_o, 0);
        end else begin
          list_result_t e;
          e = pending_q.pop_front();
          if (status_o != e.status) report_mismatch("status", status_o, e.status);
          if (count_o != e.count) report_mismatch("count", count_o, e.count);
          if (value_out_o != e.value) report_mismatch("value", value_out_o, e.value);
          if (last_o != e.last) report_mismatch("last", last_o, e.last);
        end
        result_count++;
      end
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no progress in %0d cycles", IDLE_LIMIT);
      $display("positional_list_engine_top_test: errors");
      $finish;
    end
  end

  function automatic int rand_pos();
    int s;
    s = $urandom_range(9);
    if (s == 0) return 0;
    if (s == 1) return $urandom_range(255);
    return $urandom_range(list_q.size() + 1, 1);
  endfunction

  function automatic logic [31:0] rand_value();
    case ($urandom_range(3))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      default: return $urandom;
    endcase
  endfunction

  task automatic test_directed();
    send_item(ple_pkg::K_DUMP, 0, 0);
    send_item(ple_pkg::K_DEL_FRONT, 0, 0);
    send_item(ple_pkg::K_DEL_BACK, 0, 0);
    send_item(ple_pkg::K_DEL_AT, 0, 1);
    send_item(ple_pkg::K_INS_AT, 32'h8000_0000, 0);
    send_item(ple_pkg::K_INS_AT, 32'h8000_0000, 1);
    send_item(ple_pkg::K_INS_FRONT, 32'h7fff_ffff, 0);
    send_item(ple_pkg::K_INS_BACK, 32'hffff_ffff, 255);
    send_item(ple_pkg::K_INS_AT, 32'h0, 4);
    send_item(ple_pkg::K_INS_AT, 32'h1234_5678, 2);
    send_item(ple_pkg::K_INS_AT, 32'h5a5a_a5a5, 5);
    send_item(ple_pkg::K_NOP, 32'hffff_ffff, 255);
    send_item(ple_pkg::K_DUMP, 0, 0);
    send_item(ple_pkg::K_DEL_AT, 0, 0);
    send_item(ple_pkg::K_DEL_AT, 0, 6);
    send_item(ple_pkg::K_DEL_AT, 0, 3);
    send_item(ple_pkg::K_DEL_FRONT, 0, 0);
    send_item(ple_pkg::K_DEL_BACK, 0, 0);
    send_item(ple_pkg::K_DUMP, 0, 0);
  endtask

  task automatic test_fill_and_drain();
    while (list_q.size() < CAP)
      send_item(ple_pkg::kind_e'($urandom_range(2)), rand_value(), rand_pos());
    send_item(ple_pkg::K_INS_FRONT, 1, 0);
    send_item(ple_pkg::K_INS_BACK, 2, 0);
    send_item(ple_pkg::K_INS_AT, 3, 0);
    send_item(ple_pkg::K_DUMP, 0, 0);
    send_item(ple_pkg::K_DEL_AT, 0, CAP);
    send_item(ple_pkg::K_INS_AT, 32'hdead_beef, CAP);
    send_item(ple_pkg::K_DEL_AT, 0, 1);
    while (list_q.size() > 0)
      send_item(ple_pkg::kind_e'($urandom_range(5, 3)), 0, rand_pos());
    send_item(ple_pkg::K_DUMP, 0, 0);
  endtask

  task automatic test_random(int n, int idle_pct, int stall_pct);
    ple_pkg::kind_e k;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (n) begin
      case ($urandom_range(19))
        0, 1, 2, 3: k = ple_pkg::kind_e'($urandom_range(2));
        4, 5, 6:    k = (list_q.size() > 8) ? ple_pkg::kind_e'($urandom_range(5, 3))
                                            : ple_pkg::K_INS_AT;
        7, 8:       k = ple_pkg::K_INS_AT;
        9, 10, 11:  k = ple_pkg::kind_e'($urandom_range(5, 3));
        12:         k = ple_pkg::K_DUMP;
        13:         k = ple_pkg::K_NOP;
        default:    k = (list_q.size() < 20) ? ple_pkg::kind_e'($urandom_range(2))
                                             : ple_pkg::K_DEL_AT;
      endcase
      send_item(k, rand_value(), rand_pos());
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    kind_i = '0;
    value_in_i = '0;
    position_i = '0;
    out_stall_i = 1'b0;
    error_count = 0;
    item_count = 0;
    result_count = 0;
    dump_count = 0;
    idle_cycles = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_fill_and_drain();
    test_random(70, 0, 0);
    test_random(70, 56, 0);
    test_random(70, 0, 56);
    test_random(70, 10, 10);
    send_idle_pct = 0;
    recv_stall_pct = 30;
    test_fill_and_drain();
    in_valid_i <= 1'b0;
    while (pending_q.size() > 0) @(posedge clk_i);
    recv_stall_pct = 0;
    repeat (100) @(posedge clk_i);
    $display("covered %0d items, %0d results, %0d dumps; fill to capacity and drain",
             item_count, result_count, dump_count);
    if (error_count == 0) $display("positional_list_engine_top_test: clean");
    else $display("positional_list_engine_top_test: errors");
    $finish;
  end

endmodule
